/* rtl/core/tst_pkg.sv */
// Shared types, codes and arithmetic helpers of the task-space torque solver.
`default_nettype none
package tst_pkg;

    // Word widths
    localparam int W_W   = 48;  // inner value width
    localparam int IN_W  = 32;  // loaded element and torque width
    localparam int IDX_W = 3;   // row, column and joint index width

    // Default sizes
    localparam int TASK_DIM_DEF    = 6;
    localparam int JOINT_COUNT_DEF = 7;
    localparam int FRAC_BITS_DEF   = 16;

    // Shared scratch memory
    localparam int RAM_DEPTH = 512;
    localparam int RAM_AW    = 9;

    // Serial multiplier: digits of the second operand per product
    localparam int MUL_DIGIT = 16;
    localparam int MUL_STEPS = W_W / MUL_DIGIT;

    // Opcodes
    localparam logic [1:0] OP_LD_JAC   = 2'd0;
    localparam logic [1:0] OP_LD_MASS  = 2'd1;
    localparam logic [1:0] OP_LD_FORCE = 2'd2;
    localparam logic [1:0] OP_COMPUTE  = 2'd3;

    typedef enum logic [3:0] {
        WR_LOAD, WR_RDATA, WR_ONE, WR_ZERO, WR_ACC, WR_RES, WR_A, WR_B, WR_SUB
    } t_wr_sel;

    typedef enum logic [2:0] {
        LD_NONE, LD_A, LD_B, LD_FAC, LD_PIV, LD_BEST_INIT, LD_BEST_UPD
    } t_ld;

    typedef enum logic [1:0] {
        ACC_NONE, ACC_CLR, ACC_ADD
    } t_acc;

    typedef enum logic [1:0] {
        AR_NONE, AR_MUL_AB, AR_MUL_FB, AR_DIV_AP
    } t_ar;

    // Controller to datapath
    typedef struct packed {
        logic [RAM_AW-1:0] rd_addr;
        logic              wr_en;
        logic [RAM_AW-1:0] wr_addr;
        t_wr_sel           wr_sel;
        t_ld               ld;
        logic [IDX_W-1:0]  row_tag;
        t_acc              acc;
        t_ar               ar;
        logic              emit;
        logic              emit_sing;
        logic [IDX_W-1:0]  emit_idx;
        logic              emit_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             arith_done;
        logic             best_zero;
        logic             fac_zero;
        logic [IDX_W-1:0] pidx;
    } t_sts;

    // Memory map: Jacobian, mass, force, task-space scratch T, g vector, work matrix
    function automatic logic [RAM_AW-1:0] addr_j(input logic [2:0] r, input logic [2:0] c);
        return {3'b000, r, c};
    endfunction

    function automatic logic [RAM_AW-1:0] addr_m(input logic [2:0] r, input logic [2:0] c);
        return {3'b001, r, c};
    endfunction

    function automatic logic [RAM_AW-1:0] addr_t(input logic [2:0] r, input logic [2:0] c);
        return {3'b011, r, c};
    endfunction

    function automatic logic [RAM_AW-1:0] addr_f(input logic [2:0] r);
        return {6'b010000, r};
    endfunction

    function automatic logic [RAM_AW-1:0] addr_g(input logic [2:0] r);
        return {6'b010001, r};
    endfunction

    function automatic logic [RAM_AW-1:0] addr_w(input logic [2:0] r, input logic [3:0] c);
        return {2'b10, r, c};
    endfunction

    function automatic logic [W_W-1:0] mag48(input logic [W_W-1:0] v);
        return v[W_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W_W-1:0] sat_add(input logic [W_W-1:0] x, input logic [W_W-1:0] y);
        logic [W_W:0] s;
        s = {x[W_W-1], x} + {y[W_W-1], y};
        if (s[W_W] != s[W_W-1]) begin
            return s[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end
        return s[W_W-1:0];
    endfunction

    function automatic logic [W_W-1:0] sat_sub(input logic [W_W-1:0] x, input logic [W_W-1:0] y);
        logic [W_W:0] s;
        s = {x[W_W-1], x} - {y[W_W-1], y};
        if (s[W_W] != s[W_W-1]) begin
            return s[W_W] ? {1'b1, {(W_W-1){1'b0}}} : {1'b0, {(W_W-1){1'b1}}};
        end
        return s[W_W-1:0];
    endfunction

    function automatic logic [IN_W-1:0] sat32(input logic [W_W-1:0] x);
        if ((&x[W_W-1:IN_W-1]) || !(|x[W_W-1:IN_W-1])) begin
            return x[IN_W-1:0];
        end
        return x[W_W-1] ? {1'b1, {(IN_W-1){1'b0}}} : {1'b0, {(IN_W-1){1'b1}}};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/tst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

/* rtl/core/tst_arith.sv */
// Shared serial unit: saturating fixed-point multiply and divide.
`default_nettype none
module tst_arith #(
    parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start_mul,
    input  wire logic                     i_start_div,
    input  wire logic [tst_pkg::W_W-1:0]  i_op_a,
    input  wire logic [tst_pkg::W_W-1:0]  i_op_b,
    output logic                          o_done,
    output logic      [tst_pkg::W_W-1:0]  o_res
);

    localparam int WW  = tst_pkg::W_W;
    localparam int DG  = tst_pkg::MUL_DIGIT;
    localparam int PW  = 2 * WW;
    localparam int DW  = WW + FRAC_BITS;
    localparam int CW  = $clog2(DW);
    localparam int PPW = WW + DG;

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} t_ast;

    t_ast             r_state;
    logic             r_neg;
    logic             r_is_div;
    logic [WW-1:0]    r_ua;
    logic [WW-1:0]    r_ub;
    logic [PW-1:0]    r_prod;
    logic [DW-1:0]    r_q;
    logic [WW-1:0]    r_rem;
    logic [CW-1:0]    r_cnt;

    logic [PPW-1:0]   pp;
    logic [WW:0]      rem_sh;
    logic             ge;
    logic [WW-1:0]    lim;
    logic [PW-1:0]    psh;
    logic             over;
    logic [WW-1:0]    m;

    assign pp     = {{DG{1'b0}}, r_ua} * {{WW{1'b0}}, r_ub[WW-1 -: DG]};
    assign rem_sh = {r_rem, r_q[DW-1]};
    assign ge     = rem_sh >= {1'b0, r_ub};
    assign lim    = r_neg ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    assign psh    = r_prod >> FRAC_BITS;
    assign over   = r_is_div ? (r_q > DW'(lim)) : (psh > PW'(lim));
    assign m      = over ? lim : (r_is_div ? r_q[WW-1:0] : psh[WW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_start_mul || i_start_div) begin
                        r_neg    <= i_op_a[WW-1] ^ i_op_b[WW-1];
                        r_is_div <= i_start_div;
                        r_ua     <= tst_pkg::mag48(i_op_a);
                        r_ub     <= tst_pkg::mag48(i_op_b);
                        r_prod   <= '0;
                        r_q      <= {tst_pkg::mag48(i_op_a), {FRAC_BITS{1'b0}}};
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_state  <= i_start_div ? A_DIV : A_MUL;
                    end
                end
                A_MUL: begin
                    // Shift in one digit of the second operand, most significant first
                    r_prod <= (r_prod << DG) + PW'(pp);
                    r_ub   <= r_ub << DG;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(tst_pkg::MUL_STEPS - 1)) begin
                        r_state <= A_FIN;
                    end
                end
                A_DIV: begin
                    r_rem <= ge ? WW'(rem_sh - {1'b0, r_ub}) : rem_sh[WW-1:0];
                    r_q   <= {r_q[DW-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(DW - 1)) begin
                        r_state <= A_FIN;
                    end
                end
                A_FIN: begin
                    o_res   <= r_neg ? (~m + 1'b1) : m;
                    o_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/tst_dp.sv */
// Datapath: scratch RAM, operand registers, accumulator, pivot search and result beat.
`default_nettype none
module tst_dp #(
    parameter int FRAC_BITS = tst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tst_pkg::t_cmd                 i_cmd,
    input  wire logic signed [tst_pkg::IN_W-1:0] i_value,
    output tst_pkg::t_sts                      o_sts,
    output logic                               o_strobe,
    output logic       [tst_pkg::IDX_W-1:0]    o_joint_index,
    output logic signed [tst_pkg::IN_W-1:0]    o_torque,
    output logic                               o_singular,
    output logic                               o_last
);

    localparam int WW = tst_pkg::W_W;
    localparam logic [WW-1:0] Q_ONE = WW'(1) << FRAC_BITS;

    logic [WW-1:0]            rdata;
    logic [WW-1:0]            wdata;
    logic [WW-1:0]            r_a;
    logic [WW-1:0]            r_b;
    logic [WW-1:0]            r_fac;
    logic [WW-1:0]            r_piv;
    logic [WW-1:0]            r_best;
    logic [tst_pkg::IDX_W-1:0] r_pidx;
    logic [WW-1:0]            r_acc;
    logic                     ar_done;
    logic [WW-1:0]            ar_res;
    logic [WW-1:0]            op_a;
    logic [WW-1:0]            op_b;

    tst_ram #(
        .WIDTH(WW),
        .DEPTH(tst_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (wdata),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (rdata)
    );

    assign op_a = (i_cmd.ar == tst_pkg::AR_MUL_FB) ? r_fac : r_a;
    assign op_b = (i_cmd.ar == tst_pkg::AR_DIV_AP) ? r_piv : r_b;

    tst_arith #(
        .FRAC_BITS(FRAC_BITS)
    ) u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_mul (i_cmd.ar == tst_pkg::AR_MUL_AB || i_cmd.ar == tst_pkg::AR_MUL_FB),
        .i_start_div (i_cmd.ar == tst_pkg::AR_DIV_AP),
        .i_op_a      (op_a),
        .i_op_b      (op_b),
        .o_done      (ar_done),
        .o_res       (ar_res)
    );

    always_comb begin
        unique case (i_cmd.wr_sel)
            tst_pkg::WR_LOAD:  wdata = {{(WW-tst_pkg::IN_W){i_value[tst_pkg::IN_W-1]}}, i_value};
            tst_pkg::WR_RDATA: wdata = rdata;
            tst_pkg::WR_ONE:   wdata = Q_ONE;
            tst_pkg::WR_ZERO:  wdata = '0;
            tst_pkg::WR_ACC:   wdata = r_acc;
            tst_pkg::WR_RES:   wdata = ar_res;
            tst_pkg::WR_A:     wdata = r_a;
            tst_pkg::WR_B:     wdata = r_b;
            tst_pkg::WR_SUB:   wdata = tst_pkg::sat_sub(r_a, ar_res);
            default:           wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.ld)
            tst_pkg::LD_NONE:  ;
            tst_pkg::LD_A:     r_a   <= rdata;
            tst_pkg::LD_B:     r_b   <= rdata;
            tst_pkg::LD_FAC:   r_fac <= rdata;
            tst_pkg::LD_PIV:   r_piv <= rdata;
            tst_pkg::LD_BEST_INIT: begin
                r_best <= tst_pkg::mag48(rdata);
                r_pidx <= i_cmd.row_tag;
            end
            tst_pkg::LD_BEST_UPD: begin
                // Strictly larger only: the first row of equal magnitude wins
                if (tst_pkg::mag48(rdata) > r_best) begin
                    r_best <= tst_pkg::mag48(rdata);
                    r_pidx <= i_cmd.row_tag;
                end
            end
            default: ;
        endcase
        unique case (i_cmd.acc)
            tst_pkg::ACC_NONE: ;
            tst_pkg::ACC_CLR:  r_acc <= '0;
            tst_pkg::ACC_ADD:  r_acc <= tst_pkg::sat_add(r_acc, ar_res);
            default: ;
        endcase
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            o_joint_index <= i_cmd.emit_idx;
            o_torque      <= i_cmd.emit_sing ? '0 : tst_pkg::sat32(r_acc);
            o_singular    <= i_cmd.emit_sing;
            o_last        <= i_cmd.emit_last;
        end
    end

    assign o_sts.arith_done = ar_done;
    assign o_sts.best_zero  = (r_best == '0);
    assign o_sts.fac_zero   = (r_fac == '0);
    assign o_sts.pidx       = r_pidx;

endmodule
`default_nettype wire

/* rtl/core/tst_ctrl.sv */
// Controller: sequences loads, both inversions, the matrix products and the torque beats.
`default_nettype none
module tst_ctrl #(
    parameter int TASK_DIM    = tst_pkg::TASK_DIM_DEF,
    parameter int JOINT_COUNT = tst_pkg::JOINT_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [tst_pkg::IDX_W-1:0]  i_row,
    input  wire logic [tst_pkg::IDX_W-1:0]  i_column,
    input  wire tst_pkg::t_sts              i_sts,
    output tst_pkg::t_cmd                   o_cmd,
    output logic                            o_busy
);

    localparam logic [2:0] TD3   = 3'(TASK_DIM);
    localparam logic [2:0] JC3   = 3'(JOINT_COUNT);
    localparam logic [2:0] TD_M1 = 3'(TASK_DIM - 1);
    localparam logic [2:0] JC_M1 = 3'(JOINT_COUNT - 1);

    typedef enum logic [5:0] {
        S_IDLE, S_FILL, S_FILL_WR,
        S_PV_RD, S_PV_INIT, S_PV_SCAN, S_PV_CHK,
        S_SW_RDP, S_SW_RDC, S_SW_WRC, S_SW_WRP,
        S_NM_RD0, S_NM_PIV, S_NM_RD, S_NM_LD, S_NM_GO, S_NM_WAIT,
        S_EL_ROW, S_EL_FAC, S_EL_CHK, S_EL_RDC, S_EL_LDB, S_EL_GO, S_EL_WAIT,
        S_MM_CLR, S_MM_RDA, S_MM_RDB, S_MM_LDB, S_MM_GO, S_MM_WAIT, S_MM_WR,
        S_SING
    } t_state;

    typedef enum logic [1:0] {MM_T, MM_L, MM_G, MM_TAU} t_mode;

    t_state     r_state, n_state;
    t_mode      r_mode, n_mode;
    logic       r_phase, n_phase;
    logic [2:0] r_r, n_r;
    logic [2:0] r_c, n_c;
    logic [2:0] r_i, n_i;
    logic [2:0] r_k, n_k;
    logic [3:0] r_j, n_j;

    logic [2:0] n_dim;
    logic [2:0] nm1;
    logic [3:0] j_last;
    logic       fill_adv_last;
    logic [2:0] mm_im1, mm_jm1, mm_km1;
    logic [tst_pkg::RAM_AW-1:0] mm_a_addr, mm_b_addr, mm_d_addr;

    assign n_dim  = r_phase ? TD3 : JC3;
    assign nm1    = n_dim - 3'd1;
    assign j_last = {n_dim, 1'b0} - 4'd1;
    assign fill_adv_last = (r_j == j_last) && (r_r == nm1);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        unique case (r_mode)
            MM_T: begin
                mm_im1    = TD_M1; mm_jm1 = JC_M1; mm_km1 = JC_M1;
                mm_a_addr = tst_pkg::addr_j(r_i, r_k);
                mm_b_addr = tst_pkg::addr_w(r_k, {1'b0, JC3} + {1'b0, r_j[2:0]});
                mm_d_addr = tst_pkg::addr_t(r_i, r_j[2:0]);
            end
            MM_L: begin
                mm_im1    = TD_M1; mm_jm1 = TD_M1; mm_km1 = JC_M1;
                mm_a_addr = tst_pkg::addr_t(r_i, r_k);
                mm_b_addr = tst_pkg::addr_j(r_j[2:0], r_k);
                mm_d_addr = tst_pkg::addr_w(r_i, r_j);
            end
            MM_G: begin
                mm_im1    = TD_M1; mm_jm1 = 3'd0; mm_km1 = TD_M1;
                mm_a_addr = tst_pkg::addr_w(r_i, {1'b0, TD3} + {1'b0, r_k});
                mm_b_addr = tst_pkg::addr_f(r_k);
                mm_d_addr = tst_pkg::addr_g(r_i);
            end
            MM_TAU: begin
                mm_im1    = JC_M1; mm_jm1 = 3'd0; mm_km1 = TD_M1;
                mm_a_addr = tst_pkg::addr_j(r_k, r_i);
                mm_b_addr = tst_pkg::addr_g(r_k);
                mm_d_addr = tst_pkg::addr_g(r_i);
            end
            default: begin
                mm_im1 = '0; mm_jm1 = '0; mm_km1 = '0;
                mm_a_addr = '0; mm_b_addr = '0; mm_d_addr = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_phase = r_phase;
        n_r     = r_r;
        n_c     = r_c;
        n_i     = r_i;
        n_k     = r_k;
        n_j     = r_j;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_opcode)
                        tst_pkg::OP_LD_JAC: begin
                            o_cmd.wr_en   = (i_row < TD3) && (i_column < JC3);
                            o_cmd.wr_addr = tst_pkg::addr_j(i_row, i_column);
                        end
                        tst_pkg::OP_LD_MASS: begin
                            o_cmd.wr_en   = (i_row < JC3) && (i_column < JC3);
                            o_cmd.wr_addr = tst_pkg::addr_m(i_row, i_column);
                        end
                        tst_pkg::OP_LD_FORCE: begin
                            o_cmd.wr_en   = (i_row < TD3);
                            o_cmd.wr_addr = tst_pkg::addr_f(i_row);
                        end
                        tst_pkg::OP_COMPUTE: begin
                            n_phase = 1'b0;
                            n_r     = '0;
                            n_j     = '0;
                            n_state = S_FILL;
                        end
                        default: ;
                    endcase
                    o_cmd.wr_sel = tst_pkg::WR_LOAD;
                end
            end
            S_FILL: begin
                if (r_j < {1'b0, n_dim}) begin
                    if (!r_phase) begin
                        o_cmd.rd_addr = tst_pkg::addr_m(r_r, r_j[2:0]);
                        n_state       = S_FILL_WR;
                    end
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = tst_pkg::addr_w(r_r, r_j);
                    o_cmd.wr_sel  = ((r_j - {1'b0, n_dim}) == {1'b0, r_r}) ?
                                    tst_pkg::WR_ONE : tst_pkg::WR_ZERO;
                end
                if (r_phase || r_j >= {1'b0, n_dim}) begin
                    if (fill_adv_last) begin
                        n_c = '0; n_state = S_PV_RD;
                    end else if (r_j == j_last) begin
                        n_j = '0; n_r = r_r + 3'd1;
                    end else begin
                        n_j = r_j + 4'd1;
                    end
                end
            end
            S_FILL_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = tst_pkg::addr_w(r_r, r_j);
                o_cmd.wr_sel  = tst_pkg::WR_RDATA;
                n_state       = S_FILL;
                if (fill_adv_last) begin
                    n_c = '0; n_state = S_PV_RD;
                end else if (r_j == j_last) begin
                    n_j = '0; n_r = r_r + 3'd1;
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            S_PV_RD: begin
                o_cmd.rd_addr = tst_pkg::addr_w(r_c, {1'b0, r_c});
                n_state       = S_PV_INIT;
            end
            S_PV_INIT: begin
                o_cmd.ld      = tst_pkg::LD_BEST_INIT;
                o_cmd.row_tag = r_c;
                if (r_c == nm1) begin
                    n_state = S_PV_CHK;
                end else begin
                    o_cmd.rd_addr = tst_pkg::addr_w(r_c + 3'd1, {1'b0, r_c});
                    n_r           = r_c + 3'd1;
                    n_state       = S_PV_SCAN;
                end
            end
            S_PV_SCAN: begin
                o_cmd.ld      = tst_pkg::LD_BEST_UPD;
                o_cmd.row_tag = r_r;
                if (r_r == nm1) begin
                    n_state = S_PV_CHK;
                end else begin
                    o_cmd.rd_addr = tst_pkg::addr_w(r_r + 3'd1, {1'b0, r_c});
                    n_r           = r_r + 3'd1;
                end
            end
            S_PV_CHK: begin
                n_j = '0;
                priority if (i_sts.best_zero) begin
                    n_state = S_SING;
                end else if (i_sts.pidx != r_c) begin
                    n_state = S_SW_RDP;
                end else begin
                    n_state = S_NM_RD0;
                end
            end
            S_SW_RDP: begin
                o_cmd.rd_addr = tst_pkg::addr_w(i_sts.pidx, r_j);
                n_state       = S_SW_RDC;
            end
            S_SW_RDC: begin
                o_cmd.ld      = tst_pkg::LD_A;
                o_cmd.rd_addr = tst_pkg::addr_w(r_c, r_j);
                n_state       = S_SW_WRC;
            end
            S_SW_WRC: begin
                o_cmd.ld      = tst_pkg::LD_B;
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = tst_pkg::addr_w(r_c, r_j);
                o_cmd.wr_sel  = tst_pkg::WR_A;
                n_state       = S_SW_WRP;
            end
            S_SW_WRP: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = tst_pkg::addr_w(i_sts.pidx, r_j);
                o_cmd.wr_sel  = tst_pkg::WR_B;
                if (r_j == j_last) begin
                    n_state = S_NM_RD0;
                end else begin
                    n_j     = r_j + 4'd1;
                    n_state = S_SW_RDP;
                end
            end
            S_NM_RD0: begin
                o_cmd.rd_addr = tst_pkg::addr_w(r_c, {1'b0, r_c});
                n_state       = S_NM_PIV;
            end
            S_NM_PIV: begin
                o_cmd.ld = tst_pkg::LD_PIV;
                n_j      = '0;
                n_state  = S_NM_RD;
            end
            S_NM_RD: begin
                o_cmd.rd_addr = tst_pkg::addr_w(r_c, r_j);
                n_state       = S_NM_LD;
            end
            S_NM_LD: begin
                o_cmd.ld = tst_pkg::LD_A;
                n_state  = S_NM_GO;
            end
            S_NM_GO: begin
                o_cmd.ar = tst_pkg::AR_DIV_AP;
                n_state  = S_NM_WAIT;
            end
            S_NM_WAIT: begin
                if (i_sts.arith_done) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = tst_pkg::addr_w(r_c, r_j);
                    o_cmd.wr_sel  = tst_pkg::WR_RES;
                    if (r_j == j_last) begin
                        n_r     = '0;
                        n_state = S_EL_ROW;
                    end else begin
                        n_j     = r_j + 4'd1;
                        n_state = S_NM_RD;
                    end
                end
            end
            S_EL_ROW: begin
                priority if (r_r == n_dim) begin
                    // Column done: next pivot, or leave the inversion
                    if (r_c == nm1) begin
                        n_i = '0; n_j = '0;
                        n_mode  = r_phase ? MM_G : MM_T;
                        n_state = S_MM_CLR;
                    end else begin
                        n_c     = r_c + 3'd1;
                        n_state = S_PV_RD;
                    end
                end else if (r_r == r_c) begin
                    n_r = r_r + 3'd1;
                end else begin
                    o_cmd.rd_addr = tst_pkg::addr_w(r_r, {1'b0, r_c});
                    n_state       = S_EL_FAC;
                end
            end
            S_EL_FAC: begin
                o_cmd.ld = tst_pkg::LD_FAC;
                n_state  = S_EL_CHK;
            end
            S_EL_CHK: begin
                n_j = '0;
                if (i_sts.fac_zero) begin
                    n_r     = r_r + 3'd1;
                    n_state = S_EL_ROW;
                end else begin
                    n_state = S_EL_RDC;
                end
            end
            S_EL_RDC: begin
                o_cmd.rd_addr = tst_pkg::addr_w(r_c, r_j);
                n_state       = S_EL_LDB;
            end
            S_EL_LDB: begin
                o_cmd.ld      = tst_pkg::LD_B;
                o_cmd.rd_addr = tst_pkg::addr_w(r_r, r_j);
                n_state       = S_EL_GO;
            end
            S_EL_GO: begin
                o_cmd.ld = tst_pkg::LD_A;
                o_cmd.ar = tst_pkg::AR_MUL_FB;
                n_state  = S_EL_WAIT;
            end
            S_EL_WAIT: begin
                if (i_sts.arith_done) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = tst_pkg::addr_w(r_r, r_j);
                    o_cmd.wr_sel  = tst_pkg::WR_SUB;
                    if (r_j == j_last) begin
                        n_r     = r_r + 3'd1;
                        n_state = S_EL_ROW;
                    end else begin
                        n_j     = r_j + 4'd1;
                        n_state = S_EL_RDC;
                    end
                end
            end
            S_MM_CLR: begin
                o_cmd.acc = tst_pkg::ACC_CLR;
                n_k       = '0;
                n_state   = S_MM_RDA;
            end
            S_MM_RDA: begin
                o_cmd.rd_addr = mm_a_addr;
                n_state       = S_MM_RDB;
            end
            S_MM_RDB: begin
                o_cmd.ld      = tst_pkg::LD_A;
                o_cmd.rd_addr = mm_b_addr;
                n_state       = S_MM_LDB;
            end
            S_MM_LDB: begin
                o_cmd.ld = tst_pkg::LD_B;
                n_state  = S_MM_GO;
            end
            S_MM_GO: begin
                o_cmd.ar = tst_pkg::AR_MUL_AB;
                n_state  = S_MM_WAIT;
            end
            S_MM_WAIT: begin
                if (i_sts.arith_done) begin
                    o_cmd.acc = tst_pkg::ACC_ADD;
                    if (r_k == mm_km1) begin
                        n_state = S_MM_WR;
                    end else begin
                        n_k     = r_k + 3'd1;
                        n_state = S_MM_RDA;
                    end
                end
            end
            S_MM_WR: begin
                if (r_mode == MM_TAU) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_idx  = r_i;
                    o_cmd.emit_last = (r_i == mm_im1);
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_addr = mm_d_addr;
                    o_cmd.wr_sel  = tst_pkg::WR_ACC;
                end
                n_state = S_MM_CLR;
                if (r_j[2:0] != mm_jm1) begin
                    n_j = r_j + 4'd1;
                end else if (r_i != mm_im1) begin
                    n_j = '0;
                    n_i = r_i + 3'd1;
                end else begin
                    n_j = '0;
                    n_i = '0;
                    unique case (r_mode)
                        MM_T:   n_mode = MM_L;
                        MM_L: begin
                            n_phase = 1'b1;
                            n_r     = '0;
                            n_state = S_FILL;
                        end
                        MM_G:   n_mode = MM_TAU;
                        MM_TAU: n_state = S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SING: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_sing = 1'b1;
                o_cmd.emit_idx  = r_j[2:0];
                o_cmd.emit_last = (r_j[2:0] == JC_M1);
                if (r_j[2:0] == JC_M1) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 4'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= MM_T;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_phase <= n_phase;
        end
        r_r <= n_r;
        r_c <= n_c;
        r_i <= n_i;
        r_k <= n_k;
        r_j <= n_j;
    end

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.arith_done |-> (r_state == S_NM_WAIT || r_state == S_EL_WAIT ||
                              r_state == S_MM_WAIT))
        else $error("arith result arrived outside a wait state");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_opcode == tst_pkg::OP_COMPUTE) |=>
        (r_state == S_FILL))
        else $error("compute beat did not start the mass fill");

    a_swap_other_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_RDP) |-> (i_sts.pidx != r_c))
        else $error("row swap with itself");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE))
        else $error("run continued after the last torque");

endmodule
`default_nettype wire

/* rtl/core/task_space_torque_solver.sv */
// Top level of the task-space torque solver: controller plus datapath.
//
//  channel   direction  handshake                 payload
//  command   in         start & !busy             i_opcode, i_row, i_column, i_value
//  torque    out        o_strobe (one cycle)      o_joint_index, o_torque, o_singular, o_last
//
// A load beat leaves busy low, so loads may come back to back.
// A compute beat raises busy for the whole solve: each quotient goes through the shared
// serial divider, each product through the 16-bit-digit multiplier, and every operand
// comes through the single read port of the scratch RAM.
// The seven torque beats leave on o_strobe in joint order, the last one marked.
// Reset is synchronous and active low; it clears control state only.
// There is no backpressure: a result beat is taken in the cycle it is shown.
`default_nettype none
module task_space_torque_solver #(
    parameter int TASK_DIM    = tst_pkg::TASK_DIM_DEF,
    parameter int JOINT_COUNT = tst_pkg::JOINT_COUNT_DEF,
    parameter int FRAC_BITS   = tst_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      i_opcode,
    input  wire logic [tst_pkg::IDX_W-1:0]       i_row,
    input  wire logic [tst_pkg::IDX_W-1:0]       i_column,
    input  wire logic signed [tst_pkg::IN_W-1:0] i_value,
    output logic                                 o_strobe,
    output logic [tst_pkg::IDX_W-1:0]            o_joint_index,
    output logic signed [tst_pkg::IN_W-1:0]      o_torque,
    output logic                                 o_singular,
    output logic                                 o_last
);

    tst_pkg::t_cmd cmd;
    tst_pkg::t_sts sts;

    // Sequence the solve; issue one command word per cycle
    tst_ctrl #(
        .TASK_DIM    (TASK_DIM),
        .JOINT_COUNT (JOINT_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_row    (i_row),
        .i_column (i_column),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    // Hold the matrices, run the arithmetic, drive the torque beat
    tst_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (i_value),
        .o_sts         (sts),
        .o_strobe      (o_strobe),
        .o_joint_index (o_joint_index),
        .o_torque      (o_torque),
        .o_singular    (o_singular),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the task-space torque solver.
`timescale 1ns / 1ps
`default_nettype none

// Torque beat predicted for one joint
typedef struct {
    logic [2:0]  joint;
    logic [31:0] torque;
    logic        singular;
    logic        last;
} t_torque_beat;

// Tracks loaded matrices, predicts the torque beats of each solve and checks them.
class t_torque_scoreboard;
    localparam longint W_MAX = 64'sh00007FFFFFFFFFFF;
    localparam longint W_MIN = -W_MAX - 1;

    longint       jac[6][7];
    longint       mass[7][7];
    longint       force_vec[6];
    longint       work[7][14];
    t_torque_beat due[$];
    int           errors;

    function new();
        errors = 0;
        foreach (jac[r, c]) jac[r][c] = 0;
        foreach (mass[r, c]) mass[r][c] = 0;
        foreach (force_vec[r]) force_vec[r] = 0;
    endfunction

    function int pending();
        return due.size();
    endfunction

    function longint sat48(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Q-format product, truncated toward zero, saturated to 48 bits
    function longint mul_q(longint a, longint b);
        bit          neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        p   = ({64'd0, absval(a)} * {64'd0, absval(b)}) >> 16;
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (p > lim) p = lim;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // Q-format quotient, truncated toward zero, saturated to 48 bits
    function longint div_q(longint a, longint b);
        bit          neg;
        logic [127:0] q;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        q   = ({64'd0, absval(a)} << 16) / {64'd0, absval(b)};
        lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (q > lim) q = lim;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // Gauss-Jordan with partial pivoting; returns 0 on a zero pivot
    function bit gauss_invert(int n, input longint src[7][7], output longint dst[7][7]);
        longint piv;
        longint fac;
        longint best;
        longint tmp;
        int     p;
        foreach (dst[r, c]) dst[r][c] = 0;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < 2 * n; c++)
                work[r][c] = (c < n) ? src[r][c] : ((c - n == r) ? 64'sd65536 : 0);
        for (int c = 0; c < n; c++) begin
            best = absval(work[c][c]);
            p = c;
            for (int r = c + 1; r < n; r++)
                if (absval(work[r][c]) > best) begin
                    best = absval(work[r][c]);
                    p = r;
                end
            if (best == 0) return 0;
            if (p != c)
                for (int j = 0; j < 2 * n; j++) begin
                    tmp = work[p][j];
                    work[p][j] = work[c][j];
                    work[c][j] = tmp;
                end
            piv = work[c][c];
            for (int j = 0; j < 2 * n; j++) work[c][j] = div_q(work[c][j], piv);
            for (int r = 0; r < n; r++) begin
                fac = work[r][c];
                if (r == c || fac == 0) continue;
                for (int j = 0; j < 2 * n; j++)
                    work[r][j] = sat48(work[r][j] - mul_q(fac, work[c][j]));
            end
        end
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) dst[r][c] = work[r][n + c];
        return 1;
    endfunction

    // Solve tau = J^T * (Lambda * f) and queue the seven torque beats
    function void predict_solve();
        longint       a[7][7];
        longint       minv[7][7];
        longint       t[7][7];
        longint       lam[7][7];
        longint       g[6];
        longint       tau[7];
        longint       s;
        bit           ok;
        t_torque_beat b;
        foreach (a[r, c]) a[r][c] = (r < 7 && c < 7) ? mass[r][c] : 0;
        foreach (tau[j]) tau[j] = 0;
        ok = gauss_invert(7, a, minv);
        if (ok) begin
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 7; j++) begin
                    s = 0;
                    for (int k = 0; k < 7; k++) s = sat48(s + mul_q(jac[i][k], minv[k][j]));
                    t[i][j] = s;
                end
            foreach (a[r, c]) a[r][c] = 0;
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 6; j++) begin
                    s = 0;
                    for (int k = 0; k < 7; k++) s = sat48(s + mul_q(t[i][k], jac[j][k]));
                    a[i][j] = s;
                end
            ok = gauss_invert(6, a, lam);
        end
        if (ok) begin
            for (int i = 0; i < 6; i++) begin
                s = 0;
                for (int k = 0; k < 6; k++) s = sat48(s + mul_q(lam[i][k], force_vec[k]));
                g[i] = s;
            end
            for (int j = 0; j < 7; j++) begin
                s = 0;
                for (int i = 0; i < 6; i++) s = sat48(s + mul_q(jac[i][j], g[i]));
                tau[j] = s;
            end
        end
        for (int j = 0; j < 7; j++) begin
            if (tau[j] > 64'sd2147483647) tau[j] = 64'sd2147483647;
            if (tau[j] < -64'sd2147483648) tau[j] = -64'sd2147483648;
            b.joint    = j[2:0];
            b.torque   = tau[j][31:0];
            b.singular = !ok;
            b.last     = (j == 6);
            due.insert(due.size(), b);
        end
    endfunction

    // Note one accepted command beat
    function void note_command(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                               logic signed [31:0] val);
        case (op)
            tst_pkg::OP_LD_JAC:   if (row < 6 && col < 7) jac[row][col] = val;
            tst_pkg::OP_LD_MASS:  if (row < 7 && col < 7) mass[row][col] = val;
            tst_pkg::OP_LD_FORCE: if (row < 6) force_vec[row] = val;
            default:              predict_solve();
        endcase
    endfunction

    // Check one torque beat against the oldest prediction
    function void check_torque(logic [2:0] joint, logic [31:0] tq, logic sing, logic lst);
        t_torque_beat e;
        if (due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected torque beat: joint %0d torque %h", joint, tq);
            return;
        end
        e = due.pop_front();
        if (e.joint !== joint || e.torque !== tq || e.singular !== sing || e.last !== lst) begin
            errors++;
            if (errors <= 10)
                $display("torque mismatch: exp j%0d %h s%0b l%0b, got j%0d %h s%0b l%0b",
                         e.joint, e.torque, e.singular, e.last, joint, tq, sing, lst);
        end
    endfunction
endclass

module testbench;
    // Cycles without any beat before the run is declared hung
    localparam int HANG_LIMIT = 150000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [2:0]         i_row;
    logic [2:0]         i_column;
    logic signed [31:0] i_value;
    logic               o_strobe;
    logic [2:0]         o_joint_index;
    logic signed [31:0] o_torque;
    logic               o_singular;
    logic               o_last;

    t_torque_scoreboard sb;
    int                 sender_idle_pct;
    int                 quiet_cycles;

    task_space_torque_solver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_value       (i_value),
        .o_strobe      (o_strobe),
        .o_joint_index (o_joint_index),
        .o_torque      (o_torque),
        .o_singular    (o_singular),
        .o_last        (o_last)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Check every torque beat in the cycle it is shown; the receiver cannot stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_torque(o_joint_index, o_torque, o_singular, o_last);
        end
    end

    // Watchdog: count cycles in which no beat moves in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == HANG_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Drive one command beat at the falling edge and hold it until accepted
    task automatic send_command(logic [1:0] op, logic [2:0] row, logic [2:0] col,
                                logic signed [31:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start    = 1'b1;
        i_opcode = op;
        i_row    = row;
        i_column = col;
        i_value  = val;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_command(op, row, col, val);
    endtask

    // Drop start and hold off until every pending torque beat has arrived
    task automatic drain_torques();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Well-conditioned element: dominant mass diagonal, moderate Jacobian and force
    function automatic logic signed [31:0] sane_value(logic [1:0] op, int r, int c);
        if (op == tst_pkg::OP_LD_MASS)
            return (r == c) ? $urandom_range(8 << 16, 2 << 16)
                            : $signed($urandom_range(1 << 15)) - (1 << 14);
        if (op == tst_pkg::OP_LD_JAC) return $signed($urandom_range(1 << 17)) - (1 << 16);
        return $signed($urandom_range(100 << 16)) - (50 << 16);
    endfunction

    task automatic load_everything();
        for (int r = 0; r < 6; r++)
            for (int c = 0; c < 7; c++)
                send_command(tst_pkg::OP_LD_JAC, 3'(r), 3'(c),
                             sane_value(tst_pkg::OP_LD_JAC, r, c));
        for (int r = 0; r < 7; r++)
            for (int c = 0; c < 7; c++)
                send_command(tst_pkg::OP_LD_MASS, 3'(r), 3'(c),
                             sane_value(tst_pkg::OP_LD_MASS, r, c));
        for (int r = 0; r < 6; r++)
            send_command(tst_pkg::OP_LD_FORCE, 3'(r), 3'd0,
                         sane_value(tst_pkg::OP_LD_FORCE, r, 0));
    endtask

    // One random beat: mostly well-formed loads, some ignored or full-range noise
    task automatic random_beat();
        logic [1:0] op;
        int         r;
        int         c;
        int         pick;
        op   = 2'($urandom_range(2));
        pick = $urandom_range(99);
        r    = (op == tst_pkg::OP_LD_MASS) ? $urandom_range(6) : $urandom_range(5);
        c    = $urandom_range(6);
        if (pick < 82) begin
            send_command(op, 3'(r), 3'(c), sane_value(op, r, c));
        end else if (pick < 96) begin
            // out-of-range index: the block must drop it
            if (op == tst_pkg::OP_LD_JAC) r = $urandom_range(7, 6);
            else if (op == tst_pkg::OP_LD_MASS) r = 7;
            else r = $urandom_range(7, 6);
            send_command(op, 3'(r), 3'($urandom_range(7)), $urandom);
        end else begin
            send_command(op, 3'(r), 3'(c), $urandom);
        end
    endtask

    initial begin
        sb              = new();
        sender_idle_pct = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_opcode        = tst_pkg::OP_LD_JAC;
        i_row           = '0;
        i_column        = '0;
        i_value         = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: full load, then a plain solve
        load_everything();
        send_command(tst_pkg::OP_COMPUTE, 0, 0, 0);
        drain_torques();

        // Singular mass matrix: zero the first column
        for (int r = 0; r < 7; r++) send_command(tst_pkg::OP_LD_MASS, 3'(r), 3'd0, 0);
        send_command(tst_pkg::OP_COMPUTE, 7, 7, 32'hFFFF_FFFF);
        for (int r = 0; r < 7; r++)
            send_command(tst_pkg::OP_LD_MASS, 3'(r), 3'd0,
                         sane_value(tst_pkg::OP_LD_MASS, r, 0));

        // Singular task inertia: a zero Jacobian row makes a zero row in J*Minv*J^T
        for (int c = 0; c < 7; c++) send_command(tst_pkg::OP_LD_JAC, 3'd5, 3'(c), 0);
        send_command(tst_pkg::OP_COMPUTE, 0, 0, 0);
        for (int c = 0; c < 7; c++)
            send_command(tst_pkg::OP_LD_JAC, 3'd5, 3'(c),
                         sane_value(tst_pkg::OP_LD_JAC, 5, c));

        // Extreme values drive saturation; ignored loads at out-of-range indices
        send_command(tst_pkg::OP_LD_JAC, 0, 0, 32'sh7FFF_FFFF);
        send_command(tst_pkg::OP_LD_MASS, 1, 1, 32'sh8000_0000);
        send_command(tst_pkg::OP_LD_FORCE, 0, 0, 32'sh8000_0000);
        send_command(tst_pkg::OP_LD_FORCE, 5, 7, 32'sh7FFF_FFFF);
        send_command(tst_pkg::OP_LD_JAC, 6, 3, 32'sh1234_5678);
        send_command(tst_pkg::OP_LD_JAC, 7, 7, 32'sh8000_0000);
        send_command(tst_pkg::OP_LD_JAC, 2, 7, 32'sh7FFF_FFFF);
        send_command(tst_pkg::OP_LD_MASS, 7, 2, 32'sh5555_AAAA);
        send_command(tst_pkg::OP_LD_MASS, 3, 7, 32'shAAAA_5555);
        send_command(tst_pkg::OP_LD_FORCE, 6, 0, 32'sh7FFF_FFFF);
        send_command(tst_pkg::OP_LD_FORCE, 7, 5, 32'sh8000_0000);
        send_command(tst_pkg::OP_COMPUTE, 7, 7, 32'sh7FFF_FFFF);
        drain_torques();
        load_everything();

        // Random: sender idles 25%, then 62%, then never
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 25 : ((phase == 1) ? 62 : 0);
            for (int run = 0; run < 7; run++) begin
                repeat ($urandom_range(16, 4)) random_beat();
                if ($urandom_range(3) == 0) drain_torques();
                send_command(tst_pkg::OP_COMPUTE, 3'($urandom_range(7)),
                             3'($urandom_range(7)), $urandom);
            end
        end

        drain_torques();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire
